// ----- hdl/sdes_pkg.sv -----
// ---------------------------------------------------------------------------
// sdes_pkg
// Shared types, register codes, S-boxes and permutation helpers for the
// S-DES byte cipher pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package sdes_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_FIRST_SUBKEY   = 3'd0;
   localparam csr_index_type CSR_SECOND_SUBKEY  = 3'd1;
   localparam csr_index_type CSR_INITIAL_PERM   = 3'd2;
   localparam csr_index_type CSR_FINAL_PERM     = 3'd3;
   localparam csr_index_type CSR_HALF_SWAP_PERM = 3'd4;
   localparam csr_index_type CSR_EXPAND_PERM    = 3'd5;
   localparam csr_index_type CSR_SBOX_OUT_PERM  = 3'd6;

   localparam logic [23:0] PERM8_IDENTITY = 24'hFAC688;
   localparam logic [23:0] PERM8_SWAP     = 24'h688FAC;
   localparam logic [7:0]  PERM4_IDENTITY = 8'hE4;

   // pipeline control that travels with each byte
   typedef struct packed {
      logic valid;
      logic op;      // 0 encrypt, 1 decrypt
   } stage_ctl_type;

   localparam logic [1:0] SBOX_ZERO [16] = '{
      2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
      2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2
   };
   localparam logic [1:0] SBOX_ONE [16] = '{
      2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
      2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3
   };

   // positions are MSB-first: position p is bit 7-p
   function automatic logic [7:0] perm8(input logic [7:0] x, input logic [23:0] tbl);
      logic [7:0] r;
      logic [2:0] src;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         src = tbl[3*i +: 3];
         r[7-i] = x[3'd7 - src];
      end
      return r;
   endfunction

   function automatic logic [3:0] perm4(input logic [3:0] x, input logic [7:0] tbl);
      logic [3:0] r;
      logic [1:0] src;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         src = tbl[2*i +: 2];
         r[3-i] = x[2'd3 - src];
      end
      return r;
   endfunction

   // row from outer bits, column from inner bits
   function automatic logic [3:0] sbox_index(input logic [3:0] nib);
      return {nib[3], nib[0], nib[2:1]};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/simplified_des_byte_cipher_top.sv -----
// ---------------------------------------------------------------------------
// simplified_des_byte_cipher_top
// Five-stage S-DES byte cipher pipeline with configurable subkeys and
// permutation tables.
// ---------------------------------------------------------------------------
//  channel  ports                               direction
//  req      req_valid/req_ready, op, data_in    in
//  rsp      rsp_valid/rsp_ready, data_out       out
//  csr      csr_we, csr_index, csr_wdata        in, write only
//
//  Stages in order: IP, round 1, half swap, round 2, FP. One byte per
//  cycle sustained unless the output stalls. The last stage is the output register.
//  The whole pipeline holds when the output is valid and not taken;
//  req_ready is low only then. Synchronous reset empties all stages and
//  loads the default tables; keys reset to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module simplified_des_byte_cipher_top
   import sdes_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_op,
   input  wire logic [7:0]             req_data_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_data_out,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]  first_subkey_ff, second_subkey_ff, sbox_out_perm_ff;
   logic [23:0] initial_perm_ff, final_perm_ff, half_swap_perm_ff, expand_perm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_subkey_ff   <= 8'h00;
         second_subkey_ff  <= 8'h00;
         initial_perm_ff   <= PERM8_IDENTITY;
         final_perm_ff     <= PERM8_IDENTITY;
         half_swap_perm_ff <= PERM8_SWAP;
         expand_perm_ff    <= PERM8_IDENTITY;
         sbox_out_perm_ff  <= PERM4_IDENTITY;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_SUBKEY:   first_subkey_ff   <= csr_wdata[7:0];
            CSR_SECOND_SUBKEY:  second_subkey_ff  <= csr_wdata[7:0];
            CSR_INITIAL_PERM:   initial_perm_ff   <= csr_wdata;
            CSR_FINAL_PERM:     final_perm_ff     <= csr_wdata;
            CSR_HALF_SWAP_PERM: half_swap_perm_ff <= csr_wdata;
            CSR_EXPAND_PERM:    expand_perm_ff    <= csr_wdata;
            CSR_SBOX_OUT_PERM:  sbox_out_perm_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   stage_ctl_type ctl_req, ctl_ip, ctl_r1, ctl_sw, ctl_r2, ctl_fp;
   logic [7:0]    data_ip, data_r1, data_sw, data_r2, data_fp;
   logic          advance;

   // global hold while the output transfer is pending
   assign advance   = !ctl_fp.valid || rsp_ready;
   assign req_ready = advance;

   assign ctl_req.valid = req_valid;
   assign ctl_req.op    = req_op;

   sdes_perm_stage u_ip (
      .clock, .reset, .advance,
      .perm_table (initial_perm_ff),
      .ctl_in     (ctl_req),
      .data_in    (req_data_in),
      .ctl_out    (ctl_ip),
      .data_out   (data_ip)
   );

   sdes_round_stage u_round1 (
      .clock, .reset, .advance,
      .key_enc       (first_subkey_ff),
      .key_dec       (second_subkey_ff),
      .expand_perm   (expand_perm_ff),
      .sbox_out_perm (sbox_out_perm_ff),
      .ctl_in        (ctl_ip),
      .data_in       (data_ip),
      .ctl_out       (ctl_r1),
      .data_out      (data_r1)
   );

   sdes_perm_stage u_swap (
      .clock, .reset, .advance,
      .perm_table (half_swap_perm_ff),
      .ctl_in     (ctl_r1),
      .data_in    (data_r1),
      .ctl_out    (ctl_sw),
      .data_out   (data_sw)
   );

   sdes_round_stage u_round2 (
      .clock, .reset, .advance,
      .key_enc       (second_subkey_ff),
      .key_dec       (first_subkey_ff),
      .expand_perm   (expand_perm_ff),
      .sbox_out_perm (sbox_out_perm_ff),
      .ctl_in        (ctl_sw),
      .data_in       (data_sw),
      .ctl_out       (ctl_r2),
      .data_out      (data_r2)
   );

   sdes_perm_stage u_fp (
      .clock, .reset, .advance,
      .perm_table (final_perm_ff),
      .ctl_in     (ctl_r2),
      .data_in    (data_r2),
      .ctl_out    (ctl_fp),
      .data_out   (data_fp)
   );

   assign rsp_valid    = ctl_fp.valid;
   assign rsp_data_out = data_fp;

endmodule

`default_nettype wire

// ----- hdl/sdes_perm_stage.sv -----
// ---------------------------------------------------------------------------
// sdes_perm_stage
// One pipeline register stage applying an 8-bit bit-selection permutation.
// ---------------------------------------------------------------------------
`default_nettype none

module sdes_perm_stage
   import sdes_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic [23:0]   perm_table,
   input  wire stage_ctl_type ctl_in,
   input  wire logic [7:0]    data_in,
   output stage_ctl_type      ctl_out,
   output logic [7:0]         data_out
);

   stage_ctl_type ctl_ff;
   logic [7:0]    data_ff, data_in_perm;

   assign data_in_perm = perm8(data_in, perm_table);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.op <= ctl_in.op;
         data_ff   <= data_in_perm;
      end
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

// ----- hdl/sdes_round_stage.sv -----
// ---------------------------------------------------------------------------
// sdes_round_stage
// One pipeline register stage computing a Feistel round: EP, key XOR,
// S-boxes, P4, XOR into the left nibble.
// ---------------------------------------------------------------------------
`default_nettype none

module sdes_round_stage
   import sdes_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic [7:0]    key_enc,
   input  wire logic [7:0]    key_dec,
   input  wire logic [23:0]   expand_perm,
   input  wire logic [7:0]    sbox_out_perm,
   input  wire stage_ctl_type ctl_in,
   input  wire logic [7:0]    data_in,
   output stage_ctl_type      ctl_out,
   output logic [7:0]         data_out
);

   stage_ctl_type ctl_ff;
   logic [7:0]    data_ff, data_in_round;
   logic [7:0]    key, mixed;
   logic [3:0]    sbox_bits, f_bits;

   always_comb begin
      key       = ctl_in.op ? key_dec : key_enc;
      mixed     = perm8(data_in, expand_perm) ^ key;
      sbox_bits = {SBOX_ZERO[sbox_index(mixed[7:4])], SBOX_ONE[sbox_index(mixed[3:0])]};
      f_bits    = perm4(sbox_bits, sbox_out_perm);
      data_in_round = data_in ^ {f_bits, 4'b0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.op <= ctl_in.op;
         data_ff   <= data_in_round;
      end
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire
